// ----- rtl/ypdv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the yaw/pitch direction vector unit.
// No dependencies.
package ypdv_pkg;

   typedef struct packed {
      logic signed [17:0] yaw_angle;
      logic signed [15:0] pitch_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic signed [15:0] flat_x;
      logic signed [15:0] flat_z;
      logic signed [15:0] side_x;
      logic signed [15:0] side_z;
      logic               degenerate;
   } rsp_type;

   // angle handling, degrees * 256
   localparam logic signed [19:0] TURN_S   = 20'sd92160;
   localparam logic [16:0]        QUARTER  = 17'd23040;
   localparam logic [32:0]        ANG_K    = 33'd4797524517;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // CORDIC datapath
   localparam int CW     = 34;
   localparam int CTAG_W = 3;
   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [15:0]   ONE_Q14   = 16'sd16384;

   // square root: 46-bit radicand, one result bit per cell
   localparam int SQ_W     = 47;
   localparam int SQ_STEPS = 23;

   // divider: quotient bits, divisor width, dividend width, fraction shift
   localparam int QB   = 15;
   localparam int N_W  = 24;
   localparam int D_W  = 37;
   localparam int NSH  = 22;
   localparam int FTAG_W = 48;

   function automatic logic [31:0] atan_q30(input int idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'd843314857;
         1:  v = 32'd497837829;
         2:  v = 32'd263043837;
         3:  v = 32'd133525159;
         4:  v = 32'd67021687;
         5:  v = 32'd33543516;
         6:  v = 32'd16775851;
         7:  v = 32'd8388437;
         8:  v = 32'd4194283;
         9:  v = 32'd2097149;
         10: v = 32'd1048576;
         11: v = 32'd524288;
         12: v = 32'd262144;
         13: v = 32'd131072;
         14: v = 32'd65536;
         15: v = 32'd32768;
         16: v = 32'd16384;
         17: v = 32'd8192;
         18: v = 32'd4096;
         19: v = 32'd2048;
         20: v = 32'd1024;
         21: v = 32'd512;
         22: v = 32'd256;
         23: v = 32'd128;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/ypdv_cordic_cell.sv -----
`timescale 1ns / 1ps
// One rotation step of the CORDIC chain, registered.
// Uses ypdv_pkg for widths and the arctangent table.
module ypdv_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                              clock,
   input  logic signed [ypdv_pkg::CW-1:0]    up_x,
   input  logic signed [ypdv_pkg::CW-1:0]    up_y,
   input  logic signed [ypdv_pkg::CW-1:0]    up_z,
   input  logic [ypdv_pkg::CTAG_W-1:0]       up_tag,
   output logic signed [ypdv_pkg::CW-1:0]    dn_x,
   output logic signed [ypdv_pkg::CW-1:0]    dn_y,
   output logic signed [ypdv_pkg::CW-1:0]    dn_z,
   output logic [ypdv_pkg::CTAG_W-1:0]       dn_tag
);
   localparam int W = ypdv_pkg::CW;
   localparam logic signed [W-1:0] ANG = W'(ypdv_pkg::atan_q30(STAGE));

   logic signed [W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ypdv_pkg::CTAG_W-1:0] tag_ff;
   logic signed [W-1:0] dx, dy;

   always_comb begin
      dx = up_y >>> STAGE;
      dy = up_x >>> STAGE;
      if (!up_z[W-1]) begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - ANG;
      end else begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + ANG;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      tag_ff <= up_tag;
   end

   assign dn_x   = x_ff;
   assign dn_y   = y_ff;
   assign dn_z   = z_ff;
   assign dn_tag = tag_ff;
endmodule

// ----- rtl/ypdv_sqrt_cell.sv -----
`timescale 1ns / 1ps
// One result bit of the digit-by-digit integer square root, registered.
// Uses ypdv_pkg for the radicand width.
module ypdv_sqrt_cell #(
   parameter int STEP  = 0,
   parameter int TAG_W = 48
) (
   input  logic                          clock,
   input  logic [ypdv_pkg::SQ_W-1:0]     up_v,
   input  logic [ypdv_pkg::SQ_W-1:0]     up_res,
   input  logic [TAG_W-1:0]              up_tag,
   output logic [ypdv_pkg::SQ_W-1:0]     dn_v,
   output logic [ypdv_pkg::SQ_W-1:0]     dn_res,
   output logic [TAG_W-1:0]              dn_tag
);
   localparam int SW = ypdv_pkg::SQ_W;
   localparam logic [SW-1:0] BIT = SW'(1) << (2 * STEP);

   logic [SW-1:0] v_ff, v_in, res_ff, res_in, trial;
   logic [TAG_W-1:0] tag_ff;

   always_comb begin
      trial = up_res + BIT;
      if (up_v >= trial) begin
         v_in   = up_v - trial;
         res_in = (up_res >> 1) + BIT;
      end else begin
         v_in   = up_v;
         res_in = up_res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      res_ff <= res_in;
      tag_ff <= up_tag;
   end

   assign dn_v   = v_ff;
   assign dn_res = res_ff;
   assign dn_tag = tag_ff;
endmodule

// ----- rtl/ypdv_div_cell.sv -----
`timescale 1ns / 1ps
// One quotient bit of a restoring divider, registered.
// Uses ypdv_pkg for divisor and quotient widths.
module ypdv_div_cell (
   input  logic                        clock,
   input  logic [ypdv_pkg::N_W-1:0]    up_rem,
   input  logic [ypdv_pkg::QB-1:0]     up_num,
   input  logic [ypdv_pkg::QB-1:0]     up_quo,
   input  logic [ypdv_pkg::N_W-1:0]    up_den,
   input  logic [1:0]                  up_tag,
   output logic [ypdv_pkg::N_W-1:0]    dn_rem,
   output logic [ypdv_pkg::QB-1:0]     dn_num,
   output logic [ypdv_pkg::QB-1:0]     dn_quo,
   output logic [ypdv_pkg::N_W-1:0]    dn_den,
   output logic [1:0]                  dn_tag
);
   localparam int NW = ypdv_pkg::N_W;
   localparam int Q  = ypdv_pkg::QB;

   logic [NW:0]   t;
   logic          ge;
   logic [NW-1:0] rem_ff, rem_in, den_ff;
   logic [Q-1:0]  num_ff, num_in, quo_ff, quo_in;
   logic [1:0]    tag_ff;

   always_comb begin
      t      = {up_rem, up_num[Q-1]};
      ge     = (t >= {1'b0, up_den});
      rem_in = ge ? NW'(t - {1'b0, up_den}) : NW'(t);
      num_in = {up_num[Q-2:0], 1'b0};
      quo_in = {up_quo[Q-2:0], ge};
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= up_den;
      tag_ff <= up_tag;
   end

   assign dn_rem = rem_ff;
   assign dn_num = num_ff;
   assign dn_quo = quo_ff;
   assign dn_den = den_ff;
   assign dn_tag = tag_ff;
endmodule

// ----- rtl/yaw_pitch_direction_vectors_unit.sv -----
`timescale 1ns / 1ps
// Yaw/pitch to front, flat and right direction vectors, Q2.14.
// Pipeline: CORDIC chain, two 23-cell square root chains and two 15-cell divider
// chains. Throughput one word per cycle.
// Synchronous reset clears only the valid pipeline; busy stays low.
// Depends on ypdv_pkg, ypdv_cordic_cell, ypdv_sqrt_cell, ypdv_div_cell.
module yaw_pitch_direction_vectors_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ypdv_pkg::req_type req_data,
   output logic              rsp_valid,
   output ypdv_pkg::rsp_type rsp_data
);
   localparam int CW  = ypdv_pkg::CW;
   localparam int SQ  = ypdv_pkg::SQ_STEPS;
   localparam int SW  = ypdv_pkg::SQ_W;
   localparam int QB  = ypdv_pkg::QB;
   localparam int NW  = ypdv_pkg::N_W;
   localparam int DW  = ypdv_pkg::D_W;
   localparam int FW  = ypdv_pkg::FTAG_W;
   localparam int LAT = CORDIC_STAGES + 2 * SQ + 2 * QB + 9;

   // ---------------- helpers ----------------
   function automatic logic [16:0] wrap_turn(input logic signed [19:0] a);
      logic signed [19:0] t;
      if (a >= ypdv_pkg::TURN_S) t = a - ypdv_pkg::TURN_S;
      else if (a >= 20'sd0) t = a;
      else if (a + ypdv_pkg::TURN_S >= 20'sd0) t = a + ypdv_pkg::TURN_S;
      else t = a + ypdv_pkg::TURN_S + ypdv_pkg::TURN_S;
      return t[16:0];
   endfunction

   function automatic logic [16:0] split_quad(input logic [16:0] a);
      logic [1:0]  q;
      logic [16:0] r;
      if (a >= 17'(3) * ypdv_pkg::QUARTER) begin
         q = ypdv_pkg::QUAD_3;
         r = a - 17'(3) * ypdv_pkg::QUARTER;
      end else if (a >= 17'(2) * ypdv_pkg::QUARTER) begin
         q = ypdv_pkg::QUAD_2;
         r = a - 17'(2) * ypdv_pkg::QUARTER;
      end else if (a >= ypdv_pkg::QUARTER) begin
         q = ypdv_pkg::QUAD_1;
         r = a - ypdv_pkg::QUARTER;
      end else begin
         q = ypdv_pkg::QUAD_0;
         r = a;
      end
      return {q, r[14:0]};
   endfunction

   function automatic logic signed [15:0] rnd_clamp(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] t;
      logic signed [15:0]   o;
      t = (v + CW'(32768)) >>> 16;
      if (t < 0) o = 16'sd0;
      else if (t > CW'(16384)) o = ypdv_pkg::ONE_Q14;
      else o = 16'(t);
      return o;
   endfunction

   function automatic logic signed [31:0] rsh14(input logic signed [31:0] p);
      return (p + 32'sd8192) >>> 14;
   endfunction

   // tag: bit 1 negative, bit 0 zero divisor
   function automatic logic signed [15:0] finish(input logic [QB-1:0] q,
                                                 input logic [1:0] tag);
      logic signed [15:0] m;
      m = (q > QB'(16384)) ? ypdv_pkg::ONE_Q14 : 16'(q);
      if (tag[0]) m = 16'sd0;
      else if (tag[1]) m = -m;
      return m;
   endfunction

   // ---------------- valid pipeline ----------------
   logic [LAT-1:0] vld_ff, vld_in;
   logic           take;

   assign busy = 1'b0;
   assign take = start && !busy;
   assign vld_in = {vld_ff[LAT-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

   // ---------------- angle reduction and radians ----------------
   logic signed [19:0] ang_w [2];
   logic [16:0] wrp_w [2];
   logic [16:0] sq_w [2];
   logic [14:0] r0_ff [2];
   logic [1:0]  q0_ff [2], q1_ff [2];
   logic        zf0_ff [2], zf1_ff [2];
   logic [47:0] mprod_w [2];
   logic signed [CW-1:0] z1_ff [2];

   logic signed [CW-1:0] cx_w [2][CORDIC_STAGES+1];
   logic signed [CW-1:0] cy_w [2][CORDIC_STAGES+1];
   logic signed [CW-1:0] cz_w [2][CORDIC_STAGES+1];
   logic [ypdv_pkg::CTAG_W-1:0] ct_w [2][CORDIC_STAGES+1];

   logic signed [15:0] sn2_ff [2], cs2_ff [2];
   logic signed [15:0] s_w [2], c_w [2];

   always_comb begin
      ang_w[0] = 20'(req_data.yaw_angle);
      ang_w[1] = 20'(req_data.pitch_angle);
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      always_comb begin
         wrp_w[l]   = wrap_turn(ang_w[l]);
         sq_w[l]    = split_quad(wrp_w[l]);
         mprod_w[l] = 48'(r0_ff[l]) * 48'(ypdv_pkg::ANG_K);
      end

      always_ff @(posedge clock) begin
         r0_ff[l]  <= sq_w[l][14:0];
         q0_ff[l]  <= sq_w[l][16:15];
         zf0_ff[l] <= (sq_w[l][14:0] == 15'd0);
         z1_ff[l]  <= CW'(mprod_w[l][47:16]);
         q1_ff[l]  <= q0_ff[l];
         zf1_ff[l] <= zf0_ff[l];
      end

      assign cx_w[l][0] = ypdv_pkg::CORDIC_X0;
      assign cy_w[l][0] = '0;
      assign cz_w[l][0] = z1_ff[l];
      assign ct_w[l][0] = {q1_ff[l], zf1_ff[l]};

      for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
         ypdv_cordic_cell #(.STAGE(s)) u_cell (
            .clock  (clock),
            .up_x   (cx_w[l][s]),
            .up_y   (cy_w[l][s]),
            .up_z   (cz_w[l][s]),
            .up_tag (ct_w[l][s]),
            .dn_x   (cx_w[l][s+1]),
            .dn_y   (cy_w[l][s+1]),
            .dn_z   (cz_w[l][s+1]),
            .dn_tag (ct_w[l][s+1])
         );
      end

      // quadrant fold; exact values on quadrant boundaries
      always_comb begin
         logic signed [15:0] s0, c0;
         s0 = ct_w[l][CORDIC_STAGES][0] ? 16'sd0 : rnd_clamp(cy_w[l][CORDIC_STAGES]);
         c0 = ct_w[l][CORDIC_STAGES][0] ? ypdv_pkg::ONE_Q14
                                        : rnd_clamp(cx_w[l][CORDIC_STAGES]);
         case (ct_w[l][CORDIC_STAGES][2:1])
            ypdv_pkg::QUAD_0: begin s_w[l] = s0;  c_w[l] = c0;  end
            ypdv_pkg::QUAD_1: begin s_w[l] = c0;  c_w[l] = -s0; end
            ypdv_pkg::QUAD_2: begin s_w[l] = -s0; c_w[l] = -c0; end
            default:          begin s_w[l] = -c0; c_w[l] = s0;  end
         endcase
      end

      always_ff @(posedge clock) begin
         sn2_ff[l] <= s_w[l];
         cs2_ff[l] <= c_w[l];
      end
   end

   // ---------------- front vector ----------------
   logic signed [31:0] psc_ff, pcc_ff;
   logic signed [15:0] sp3_ff;
   logic signed [15:0] fx4_ff, fy4_ff, fz4_ff;
   logic signed [31:0] rsc_w, rcc_w;
   logic signed [31:0] fsq_w [3];
   logic [28:0]        fsq_ff [3];
   logic [FW-1:0]      f5_ff;

   always_ff @(posedge clock) begin
      psc_ff <= sn2_ff[0] * cs2_ff[1];
      pcc_ff <= cs2_ff[0] * cs2_ff[1];
      sp3_ff <= sn2_ff[1];
   end

   always_comb begin
      rsc_w = rsh14(psc_ff);
      rcc_w = rsh14(pcc_ff);
      fsq_w[0] = fx4_ff * fx4_ff;
      fsq_w[1] = fy4_ff * fy4_ff;
      fsq_w[2] = fz4_ff * fz4_ff;
   end

   always_ff @(posedge clock) begin
      fx4_ff <= 16'(-rsc_w);
      fy4_ff <= -sp3_ff;
      fz4_ff <= 16'(rcc_w);
      for (int i = 0; i < 3; i++) fsq_ff[i] <= 29'(fsq_w[i]);
      f5_ff <= {fx4_ff, fy4_ff, fz4_ff};
   end

   // ---------------- front renormalize ----------------
   logic [SW-1:0] s1v_w [SQ+1], s1r_w [SQ+1];
   logic [FW-1:0] s1t_w [SQ+1];

   assign s1v_w[0] = {1'b0, 30'(fsq_ff[0]) + 30'(fsq_ff[1]) + 30'(fsq_ff[2]), 16'd0};
   assign s1r_w[0] = '0;
   assign s1t_w[0] = f5_ff;

   for (genvar k = 0; k < SQ; k++) begin : g_sq1
      ypdv_sqrt_cell #(.STEP(SQ - 1 - k), .TAG_W(FW)) u_cell (
         .clock  (clock),
         .up_v   (s1v_w[k]),
         .up_res (s1r_w[k]),
         .up_tag (s1t_w[k]),
         .dn_v   (s1v_w[k+1]),
         .dn_res (s1r_w[k+1]),
         .dn_tag (s1t_w[k+1])
      );
   end

   logic [NW-1:0] d1rem_w [3][QB+1], d1den_w [3][QB+1];
   logic [QB-1:0] d1num_w [3][QB+1], d1quo_w [3][QB+1];
   logic [1:0]    d1tag_w [3][QB+1];
   logic signed [15:0] fin1_ff [3];

   for (genvar c = 0; c < 3; c++) begin : g_dv1
      always_comb begin
         logic signed [15:0] v;
         logic [14:0]        mag;
         logic [NW-1:0]      n;
         logic [DW-1:0]      d;
         v   = s1t_w[SQ][FW-1-16*c -: 16];
         mag = 15'(v[15] ? -v : v);
         n   = NW'(s1r_w[SQ]);
         d   = (DW'(mag) << ypdv_pkg::NSH) + DW'(n >> 1);
         d1rem_w[c][0] = NW'(d[DW-1:QB]);
         d1num_w[c][0] = d[QB-1:0];
         d1quo_w[c][0] = '0;
         d1den_w[c][0] = n;
         d1tag_w[c][0] = {v[15], n == '0};
      end

      for (genvar k = 0; k < QB; k++) begin : g_cell
         ypdv_div_cell u_cell (
            .clock  (clock),
            .up_rem (d1rem_w[c][k]),
            .up_num (d1num_w[c][k]),
            .up_quo (d1quo_w[c][k]),
            .up_den (d1den_w[c][k]),
            .up_tag (d1tag_w[c][k]),
            .dn_rem (d1rem_w[c][k+1]),
            .dn_num (d1num_w[c][k+1]),
            .dn_quo (d1quo_w[c][k+1]),
            .dn_den (d1den_w[c][k+1]),
            .dn_tag (d1tag_w[c][k+1])
         );
      end

      always_ff @(posedge clock) begin
         fin1_ff[c] <= finish(d1quo_w[c][QB], d1tag_w[c][QB]);
      end
   end

   // ---------------- flat vector ----------------
   logic signed [31:0] hsq_w [2];
   logic [28:0]        hsq_ff [2];
   logic [FW-1:0]      f9_ff;

   always_comb begin
      hsq_w[0] = fin1_ff[0] * fin1_ff[0];
      hsq_w[1] = fin1_ff[2] * fin1_ff[2];
   end

   always_ff @(posedge clock) begin
      hsq_ff[0] <= 29'(hsq_w[0]);
      hsq_ff[1] <= 29'(hsq_w[1]);
      f9_ff     <= {fin1_ff[0], fin1_ff[1], fin1_ff[2]};
   end

   logic [SW-1:0] s2v_w [SQ+1], s2r_w [SQ+1];
   logic [FW-1:0] s2t_w [SQ+1];

   assign s2v_w[0] = {1'b0, 30'(hsq_ff[0]) + 30'(hsq_ff[1]), 16'd0};
   assign s2r_w[0] = '0;
   assign s2t_w[0] = f9_ff;

   for (genvar k = 0; k < SQ; k++) begin : g_sq2
      ypdv_sqrt_cell #(.STEP(SQ - 1 - k), .TAG_W(FW)) u_cell (
         .clock  (clock),
         .up_v   (s2v_w[k]),
         .up_res (s2r_w[k]),
         .up_tag (s2t_w[k]),
         .dn_v   (s2v_w[k+1]),
         .dn_res (s2r_w[k+1]),
         .dn_tag (s2t_w[k+1])
      );
   end

   // front words ride alongside the second divider chain
   logic [FW-1:0] fd_ff [QB];

   always_ff @(posedge clock) begin
      fd_ff[0] <= s2t_w[SQ];
      for (int i = 1; i < QB; i++) fd_ff[i] <= fd_ff[i-1];
   end

   logic [NW-1:0] d2rem_w [2][QB+1], d2den_w [2][QB+1];
   logic [QB-1:0] d2num_w [2][QB+1], d2quo_w [2][QB+1];
   logic [1:0]    d2tag_w [2][QB+1];
   logic signed [15:0] fin2_w [2];

   for (genvar c = 0; c < 2; c++) begin : g_dv2
      always_comb begin
         logic signed [15:0] v;
         logic [14:0]        mag;
         logic [NW-1:0]      n;
         logic [DW-1:0]      d;
         v   = s2t_w[SQ][FW-1-32*c -: 16];
         mag = 15'(v[15] ? -v : v);
         n   = NW'(s2r_w[SQ]);
         d   = (DW'(mag) << ypdv_pkg::NSH) + DW'(n >> 1);
         d2rem_w[c][0] = NW'(d[DW-1:QB]);
         d2num_w[c][0] = d[QB-1:0];
         d2quo_w[c][0] = '0;
         d2den_w[c][0] = n;
         d2tag_w[c][0] = {v[15], n == '0};
      end

      for (genvar k = 0; k < QB; k++) begin : g_cell
         ypdv_div_cell u_cell (
            .clock  (clock),
            .up_rem (d2rem_w[c][k]),
            .up_num (d2num_w[c][k]),
            .up_quo (d2quo_w[c][k]),
            .up_den (d2den_w[c][k]),
            .up_tag (d2tag_w[c][k]),
            .dn_rem (d2rem_w[c][k+1]),
            .dn_num (d2num_w[c][k+1]),
            .dn_quo (d2quo_w[c][k+1]),
            .dn_den (d2den_w[c][k+1]),
            .dn_tag (d2tag_w[c][k+1])
         );
      end

      assign fin2_w[c] = finish(d2quo_w[c][QB], d2tag_w[c][QB]);
   end

   // ---------------- output word ----------------
   ypdv_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.front_x    = fd_ff[QB-1][47:32];
      rsp_in.front_y    = fd_ff[QB-1][31:16];
      rsp_in.front_z    = fd_ff[QB-1][15:0];
      rsp_in.flat_x     = fin2_w[0];
      rsp_in.flat_z     = fin2_w[1];
      rsp_in.side_x     = -fin2_w[1];
      rsp_in.side_z     = fin2_w[0];
      rsp_in.degenerate = d2tag_w[0][QB][0];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.flat_x == 16'sd0 && rsp_data.flat_z == 16'sd0)
      else $error("degenerate word with nonzero flat vector");

   a_flat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.flat_x <= 16'sd16384 && rsp_data.flat_x >= -16'sd16384
                    && rsp_data.front_y <= 16'sd16384 && rsp_data.front_y >= -16'sd16384)
      else $error("output component out of unit range");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");
`endif
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for yaw_pitch_direction_vectors_unit: directed table, then random angle pairs.
// Words without a typed expectation are predicted by a local fixed-point model; depends on ypdv_pkg and the RTL.
module testbench;

   localparam int STAGES  = 16;
   localparam int LATENCY = STAGES + 85;
   localparam longint ANGLE_K = 64'd4797524517;
   localparam longint X_INIT  = 64'd652032874;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   ypdv_pkg::req_type req_data = '0;
   logic              rsp_valid;
   ypdv_pkg::rsp_type rsp_data;

   ypdv_pkg::rsp_type vec_queue[$];
   int                errors = 0;

   yaw_pitch_direction_vectors_unit #(.CORDIC_STAGES(STAGES)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

   function automatic longint atan_step(int i);
      longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                        262144, 131072, 65536, 32768, 16384, 8192,
                        4096, 2048, 1024, 512, 256, 128};
      return t[i];
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip_one(longint v);
      return v > 16384 ? 16384 : (v < 0 ? 0 : v);
   endfunction

   function automatic void sin_cos(input longint ang, output longint sn,
                                   output longint cs);
      longint a, q, r, s, c, x, y, z, dx, dy;
      a = ang % 92160;
      if (a < 0) a += 92160;
      q = a / 23040;
      r = a % 23040;
      if (r == 0) begin
         s = 0;
         c = 16384;
      end else begin
         z = longint'((64'(r) * 64'(ANGLE_K)) >> 16);
         x = X_INIT;
         y = 0;
         for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_step(i);
            end else begin
               x += dx; y -= dy; z += atan_step(i);
            end
         end
         c = clip_one(rnd_shift(x, 16));
         s = clip_one(rnd_shift(y, 16));
      end
      case (q)
         0: begin sn = s;  cs = c;  end
         1: begin sn = c;  cs = -s; end
         2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint scale_to_unit(longint c, longint n);
      longint unsigned m, q;
      m = c < 0 ? -c : c;
      q = ((m << 22) + n / 2) / n;
      if (q > 16384) q = 16384;
      return c < 0 ? -longint'(q) : longint'(q);
   endfunction

   // returns 0 when the norm is zero (all components cleared)
   function automatic bit unit_vec(inout longint a, inout longint b, inout longint c);
      longint n;
      n = int_sqrt(longint'(a * a + b * b + c * c) << 16);
      if (n == 0) begin
         a = 0; b = 0; c = 0;
         return 0;
      end
      a = scale_to_unit(a, n);
      b = scale_to_unit(b, n);
      c = scale_to_unit(c, n);
      return 1;
   endfunction

   function automatic ypdv_pkg::rsp_type direction_of(ypdv_pkg::req_type w);
      longint sy, cy, sp, cp, fx, fy, fz, hx, hy, hz;
      bit ok;
      ypdv_pkg::rsp_type r;
      sin_cos(longint'(w.yaw_angle), sy, cy);
      sin_cos(longint'(w.pitch_angle), sp, cp);
      fx = -rnd_shift(sy * cp, 14);
      fy = -sp;
      fz = rnd_shift(cy * cp, 14);
      ok = unit_vec(fx, fy, fz);
      hx = fx; hy = 0; hz = fz;
      ok = unit_vec(hx, hy, hz);
      r.front_x = 16'(fx); r.front_y = 16'(fy); r.front_z = 16'(fz);
      r.flat_x = 16'(hx); r.flat_z = 16'(hz);
      r.side_x = 16'(-hz); r.side_z = 16'(hx);
      r.degenerate = !ok;
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (vec_queue.size() == 0) begin
            $display("%0t: unexpected word, actual %p", $time, rsp_data);
            errors++;
         end else begin
            ypdv_pkg::rsp_type e;
            e = vec_queue.pop_front();
            if (e !== rsp_data) begin
               $display("%0t: mismatch, expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   task automatic send_word(ypdv_pkg::req_type w, bit typed, ypdv_pkg::rsp_type want);
      start <= 1;
      req_data <= w;
      do @(posedge clock); while (busy);
      vec_queue.push_back(typed ? want : direction_of(w));
      @(negedge clock);
   endtask

   typedef struct {
      logic signed [17:0] yaw;
      logic signed [15:0] pitch;
      bit                 typed;
      ypdv_pkg::rsp_type  want;
   } stim_row;

   stim_row rows[$];

   function automatic ypdv_pkg::rsp_type vec(int fx, int fy, int fz, int hx, int hz, bit d);
      ypdv_pkg::rsp_type r;
      r.front_x = 16'(fx); r.front_y = 16'(fy); r.front_z = 16'(fz);
      r.flat_x = 16'(hx); r.flat_z = 16'(hz); r.side_x = 16'(-hz); r.side_z = 16'(hx);
      r.degenerate = d;
      return r;
   endfunction

   initial begin
      ypdv_pkg::req_type w;
      int                burst;
      // exact quadrants, straight up/down, range extremes, wraps and other directed angles
      rows.push_back('{0, 0, 1, vec(0, 0, 16384, 0, 16384, 0)});
      rows.push_back('{23040, 0, 1, vec(-16384, 0, 0, -16384, 0, 0)});
      rows.push_back('{46080, 0, 1, vec(0, 0, -16384, 0, -16384, 0)});
      rows.push_back('{-23040, 0, 1, vec(16384, 0, 0, 16384, 0, 0)});
      rows.push_back('{92160, 0, 1, vec(0, 0, 16384, 0, 16384, 0)});
      rows.push_back('{-92160, 0, 1, vec(0, 0, 16384, 0, 16384, 0)});
      rows.push_back('{0, 23040, 1, vec(0, -16384, 0, 0, 0, 1)});
      rows.push_back('{0, -23040, 1, vec(0, 16384, 0, 0, 0, 1)});
      rows.push_back('{12345, 23040, 0, '0});
      rows.push_back('{131071, 32767, 0, '0});
      rows.push_back('{-131072, -32768, 0, '0});
      rows.push_back('{1, 1, 0, '0});
      rows.push_back('{-1, -1, 0, '0});
      rows.push_back('{11520, 11520, 0, '0});
      rows.push_back('{23039, 23039, 0, '0});
      rows.push_back('{-69120, -23039, 0, '0});
      rows.push_back('{0, 23041, 0, '0});
      rows.push_back('{46080, -30720, 0, '0});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (rows[i]) begin
         w.yaw_angle = rows[i].yaw;
         w.pitch_angle = rows[i].pitch;
         send_word(w, rows[i].typed, rows[i].want);
      end

      for (int n = 0; n < 700;) begin
         burst = $urandom_range(1, 30);
         for (int k = 0; k < burst; k++, n++) begin
            case ($urandom_range(0, 9))
               0: begin
                  w.yaw_angle = 18'($urandom);
                  w.pitch_angle = 16'($urandom);
               end
               1: begin
                  w.yaw_angle = 18'($urandom_range(0, 8) * 11520 - 46080);
                  w.pitch_angle = $urandom_range(0, 1) ? 16'sd23040 : -16'sd23040;
               end
               default: begin
                  w.yaw_angle = 18'($urandom_range(0, 184320) - 92160);
                  w.pitch_angle = 16'($urandom_range(0, 46080) - 23040);
               end
            endcase
            send_word(w, 0, '0);
         end
         if ($urandom_range(0, 3) != 0) begin
            start <= 0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
      start <= 0;

      while (vec_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
